@@ sv/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Screen geometry, request and operation codes, payload and queue types.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // Field widths
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;
  localparam int IDX_W  = 11;

  // Character and attribute constants
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] RESET_ATTR   = 8'h0F;

  // Request codes
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_BKSP  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // Back-end operation codes
  localparam logic [2:0] OP_NOP          = 3'd0;
  localparam logic [2:0] OP_WRITE        = 3'd1;
  localparam logic [2:0] OP_WRITE_SCROLL = 3'd2;
  localparam logic [2:0] OP_SCROLL       = 3'd3;
  localparam logic [2:0] OP_CLEAR        = 3'd4;
  localparam logic [2:0] OP_READ         = 3'd5;

  // Command queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]       req_type;
    logic [7:0]       char_code;
    logic [IDX_W-1:0] cell_index;
  } in_payload_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } out_payload_t;

  // One classified command, front to back
  typedef struct packed {
    logic [2:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] wdata;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
    logic              scrolled;
  } cmd_t;

endpackage

`default_nettype wire

@@ sv/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port and one read port, registered read data held between reads.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/tcw_front.sv @@
// ----------------------------------------------------------------------------
// tcw_front: request decode and cursor tracking
// Accepts requests, updates the cursor and the attribute register, and turns
// each request into one memory command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front import tcw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_payload_t in_data,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        q_full,
  input  wire logic        init_busy,
  output logic             push,
  output cmd_t             push_cmd
);

  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [7:0]       attr_r;

  // Attribute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= RESET_ATTR;
    end else if (cfg_wr_en) begin
      attr_r <= cfg_wr_data;
    end
  end

  assign in_ready = !q_full && !init_busy;
  assign push     = in_valid && in_ready;

  // Cursor update and command build
  always_comb begin
    logic [ADDR_W-1:0] base;
    logic              last_row;
    base     = ADDR_W'(row_r) * ADDR_W'(COLUMNS);
    last_row = (row_r == ROW_W'(ROWS - 1));
    row_nxt  = row_r;
    col_nxt  = col_r;
    push_cmd = '0;
    push_cmd.op = OP_NOP;
    case (in_data.req_type)
      REQ_PUT: begin
        if (in_data.char_code == NEWLINE_CHAR) begin
          col_nxt = '0;
          if (last_row) begin
            push_cmd.op       = OP_SCROLL;
            push_cmd.scrolled = 1'b1;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end else begin
          push_cmd.addr  = base + ADDR_W'(col_r);
          push_cmd.wdata = {attr_r, in_data.char_code};
          push_cmd.op    = OP_WRITE;
          if (col_r == COL_W'(COLUMNS - 1)) begin
            col_nxt = '0;
            if (last_row) begin
              push_cmd.op       = OP_WRITE_SCROLL;
              push_cmd.scrolled = 1'b1;
            end else begin
              row_nxt = row_r + 1'b1;
            end
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      REQ_BKSP: begin
        if (col_r != '0) begin
          col_nxt        = col_r - 1'b1;
          push_cmd.addr  = base + ADDR_W'(col_nxt);
          push_cmd.wdata = {attr_r, BLANK_CHAR};
          push_cmd.op    = OP_WRITE;
        end
      end
      REQ_CLEAR: begin
        row_nxt        = '0;
        col_nxt        = '0;
        push_cmd.wdata = {attr_r, BLANK_CHAR};
        push_cmd.op    = OP_CLEAR;
      end
      REQ_READ: begin
        // out-of-range index reads as zero with no memory access
        if (in_data.cell_index < IDX_W'(CELL_COUNT)) begin
          push_cmd.addr = ADDR_W'(in_data.cell_index);
          push_cmd.op   = OP_READ;
        end
      end
      default: begin
        push_cmd.op = OP_NOP;
      end
    endcase
    push_cmd.cursor_row    = row_nxt;
    push_cmd.cursor_column = col_nxt;
  end

  // Cursor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (push) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/tcw_queue.sv @@
// ----------------------------------------------------------------------------
// tcw_queue: command queue between front and back end
// Small register FIFO; the head entry stays put until the back end pops it.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_queue import tcw_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  output logic      head_valid,
  output cmd_t      head,
  input  wire logic pop
);

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entry_r[rd_ptr_r];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/tcw_back.sv @@
// ----------------------------------------------------------------------------
// tcw_back: memory sequencer and result register
// Carries out queued commands on the cell memory (single writes, reads, the
// row-up copy for scrolling, full fills) and delivers one result per command.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back import tcw_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   head_valid,
  input  wire cmd_t   head,
  output logic        pop,
  output logic        init_busy,
  output logic        out_valid,
  input  wire logic   out_ready,
  output out_payload_t out_data
);

  localparam logic [1:0] S_FILL    = 2'd0;
  localparam logic [1:0] S_IDLE    = 2'd1;
  localparam logic [1:0] S_SCROLL  = 2'd2;
  localparam logic [1:0] S_DELIVER = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              init_r, init_nxt;
  logic [CELL_W-1:0] fill_word_r, fill_word_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_payload_t      out_data_r, out_data_nxt;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;
  logic              out_free;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign init_busy = init_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    init_nxt      = init_r;
    fill_word_nxt = fill_word_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_waddr     = head.addr;
    ram_wdata     = head.wdata;
    ram_re        = 1'b0;
    ram_raddr     = head.addr;
    pop           = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (head_valid) begin
          cnt_nxt = '0;
          case (head.op)
            OP_WRITE: begin
              ram_we    = 1'b1;
              state_nxt = S_DELIVER;
            end
            OP_WRITE_SCROLL: begin
              ram_we    = 1'b1;
              state_nxt = S_SCROLL;
            end
            OP_SCROLL: begin
              state_nxt = S_SCROLL;
            end
            OP_CLEAR: begin
              fill_word_nxt = head.wdata;
              state_nxt     = S_FILL;
            end
            OP_READ: begin
              ram_re    = 1'b1;
              state_nxt = S_DELIVER;
            end
            default: begin
              state_nxt = S_DELIVER;
            end
          endcase
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = fill_word_r;
        if (cnt_r == ADDR_W'(CELL_COUNT - 1)) begin
          if (init_r) begin
            init_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DELIVER;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SCROLL: begin
        // read one row down, write it back in the following cycle
        ram_we    = wr_pend_r;
        ram_waddr = wr_addr_r;
        ram_wdata = ram_rdata;
        if (cnt_r < ADDR_W'(MOVE_COUNT)) begin
          ram_re      = 1'b1;
          ram_raddr   = cnt_r + ADDR_W'(COLUMNS);
          wr_pend_nxt = 1'b1;
          wr_addr_nxt = cnt_r;
          cnt_nxt     = cnt_r + 1'b1;
        end else if (!wr_pend_r) begin
          state_nxt = S_DELIVER;
        end
      end
      S_DELIVER: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.cursor_row    = head.cursor_row;
          out_data_nxt.cursor_column = head.cursor_column;
          out_data_nxt.scrolled      = head.scrolled;
          out_data_nxt.cell_data     = (head.op == OP_READ) ? ram_rdata : '0;
          pop                        = 1'b1;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      cnt_r       <= '0;
      init_r      <= 1'b1;
      fill_word_r <= {RESET_ATTR, BLANK_CHAR};
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      init_r      <= init_nxt;
      fill_word_r <= fill_word_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    wr_addr_r  <= wr_addr_nxt;
    out_data_r <= out_data_nxt;
  end

  // Scroll copy never writes the cell it is reading
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("scroll read and write hit the same cell");

  // No command is retired during the clearing pass after reset
  a_no_pop_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_r |-> !pop)
    else $error("command retired during clearing pass");

  // A result is only delivered when the slot is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> ($stable(out_data_r) && out_valid_r))
    else $error("pending result overwritten");

  // Copy counter never passes the end of the moved region
  a_scroll_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCROLL) |-> (cnt_r <= ADDR_W'(MOVE_COUNT)))
    else $error("scroll counter out of range");

  // Popping requires a queued command
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ sv/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console engine
// 80x25 cell memory with cursor, put/backspace/clear/read requests.
// ----------------------------------------------------------------------------
// A front end takes one request per cycle, unless the queue is full or the
// clearing pass runs, into a two-entry command queue and works out the cursor
// at once; the back end works the single-port-pair cell memory, which sets
// the rate. Put, backspace, newline without scroll and read pass through the
// idle and deliver states of the back end. A scroll (newline or wrap on the
// last row) copies (ROWS-1)*COLUMNS cells at one cell per cycle; clear fills
// all ROWS*COLUMNS cells. After reset a clearing pass writes space/0x0F to
// every cell and in_ready stays low meanwhile. Results come out in request
// order, one per request, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer import tcw_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire in_payload_t  in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output out_payload_t      out_data,
  input  wire logic         cfg_wr_en,
  input  wire logic [7:0]   cfg_wr_data
);

  logic q_full, q_push, q_pop, q_head_valid, init_busy;
  cmd_t q_push_cmd, q_head;

  // Request decode and cursor
  tcw_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .init_busy   (init_busy),
    .push        (q_push),
    .push_cmd    (q_push_cmd)
  );

  // Command queue
  tcw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  // Memory sequencer and results
  tcw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .init_busy  (init_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for text_console_writer
// Drives put, backspace, clear and read requests over valid/ready with random
// idling on both sides and checks every response against a local model of the
// cell memory, the cursor and the attribute register.
// ----------------------------------------------------------------------------

module testbench;
  import tcw_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = CELL_COUNT + 100;
  localparam int DRAIN_CYCLES  = CELL_COUNT + 100;
  localparam int PASS_BUDGET   = 150;

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_ready;
  in_payload_t  in_data;
  logic         out_valid;
  logic         out_ready;
  out_payload_t out_data;
  logic         cfg_wr_en;
  logic [7:0]   cfg_wr_data;

  // Console model state
  logic [CELL_W-1:0] screen_mem [CELL_COUNT];
  logic [ROW_W-1:0]  cursor_row_q;
  logic [COL_W-1:0]  cursor_col_q;
  logic [7:0]        text_attr;

  out_payload_t pending_responses [$];

  int send_idle_pct;
  int recv_stall_pct;
  int full_pass_budget;
  int cycle_count;
  int error_count;
  int response_count;
  int count_by_kind [4];
  int scroll_total;
  int oob_reads;

  text_console_writer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Console model
  // --------------------------------------------------------------------------
  function automatic void reset_console();
    foreach (screen_mem[i]) screen_mem[i] = {RESET_ATTR, BLANK_CHAR};
    cursor_row_q = '0;
    cursor_col_q = '0;
    text_attr    = RESET_ATTR;
  endfunction

  // Move to column 0 of the next row; on the last row the screen shifts up
  // one row and the bottom row keeps its old contents.
  function automatic bit advance_row();
    cursor_col_q = '0;
    if (cursor_row_q == ROWS - 1) begin
      for (int i = 0; i < MOVE_COUNT; i++) screen_mem[i] = screen_mem[i + COLUMNS];
      return 1'b1;
    end
    cursor_row_q = cursor_row_q + 1'b1;
    return 1'b0;
  endfunction

  // Apply one request to the model and return the console's response
  function automatic out_payload_t console_response(input in_payload_t req);
    out_payload_t res;
    res = '0;
    case (req.req_type)
      REQ_PUT: begin
        if (req.char_code == NEWLINE_CHAR) begin
          res.scrolled = advance_row();
        end else begin
          screen_mem[cursor_row_q * COLUMNS + cursor_col_q] = {text_attr, req.char_code};
          cursor_col_q = cursor_col_q + 1'b1;
          if (cursor_col_q >= COLUMNS) res.scrolled = advance_row();
        end
      end
      REQ_BKSP: begin
        if (cursor_col_q != 0) begin
          cursor_col_q = cursor_col_q - 1'b1;
          screen_mem[cursor_row_q * COLUMNS + cursor_col_q] = {text_attr, BLANK_CHAR};
        end
      end
      REQ_CLEAR: begin
        foreach (screen_mem[i]) screen_mem[i] = {text_attr, BLANK_CHAR};
        cursor_row_q = '0;
        cursor_col_q = '0;
      end
      REQ_READ: begin
        if (req.cell_index < CELL_COUNT) res.cell_data = screen_mem[req.cell_index];
      end
    endcase
    res.cursor_row    = cursor_row_q;
    res.cursor_column = cursor_col_q;
    return res;
  endfunction

  // True when the request makes the back end clear or scroll the screen memory
  function automatic bit causes_full_pass(input in_payload_t req);
    if (req.req_type == REQ_CLEAR) return 1'b1;
    if (req.req_type != REQ_PUT || cursor_row_q != ROWS - 1) return 1'b0;
    return req.char_code == NEWLINE_CHAR || cursor_col_q == COLUMNS - 1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic in_payload_t make_req(input logic [1:0] kind, input logic [7:0] ch,
                                           input int idx);
    in_payload_t r;
    r.req_type   = kind;
    r.char_code  = ch;
    r.cell_index = IDX_W'(idx);
    return r;
  endfunction

  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == NEWLINE_CHAR);
    return c;
  endfunction

  function automatic int cursor_cell();
    return cursor_row_q * COLUMNS + cursor_col_q;
  endfunction

  // One request transfer; the response is predicted at the accepting edge
  task automatic send_request(input in_payload_t req);
    out_payload_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    want = console_response(req);
    pending_responses.push_back(want);
    count_by_kind[req.req_type]++;
    if (want.scrolled) scroll_total++;
    if (req.req_type == REQ_READ && req.cell_index >= CELL_COUNT) oob_reads++;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_responses.size() != 0);
  endtask

  task automatic set_attribute(input logic [7:0] value);
    wait_for_drain();
    // wait long enough for a full memory sweep before changing the attribute
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    text_attr = value;
  endtask

  // --------------------------------------------------------------------------
  // Response checking
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_responses
    out_payload_t want;
    if (out_valid === 1'b1 && out_ready === 1'b1) begin
      response_count++;
      if (pending_responses.size() == 0) begin
        $error("response with none outstanding: row %0d col %0d data %h",
               out_data.cursor_row, out_data.cursor_column, out_data.cell_data);
        error_count++;
      end else begin
        want = pending_responses.pop_front();
        check_field("cursor_row", want.cursor_row, out_data.cursor_row);
        check_field("cursor_column", want.cursor_column, out_data.cursor_column);
        check_field("cell_data", want.cell_data, out_data.cell_data);
        check_field("scrolled", want.scrolled, out_data.scrolled);
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, pending_responses.size());
      $display("** text_console_writer: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset contents, out-of-range reads, character extremes, backspace at
  // column zero, newline, clear; unused fields carry junk throughout
  task automatic test_reset_and_edges();
    send_request(make_req(REQ_READ, 8'h00, 0));
    send_request(make_req(REQ_READ, 8'hFF, CELL_COUNT - 1));
    send_request(make_req(REQ_READ, 8'h00, CELL_COUNT));
    send_request(make_req(REQ_READ, 8'h5A, 'h7FF));
    send_request(make_req(REQ_BKSP, 8'h41, 'h7FF));
    // top bit of the character must stay unsigned
    send_request(make_req(REQ_PUT, 8'h00, 'h7FF));
    send_request(make_req(REQ_PUT, 8'hFF, 0));
    send_request(make_req(REQ_PUT, 8'h80, 'h2AA));
    send_request(make_req(REQ_PUT, 8'h7F, 'h555));
    send_request(make_req(REQ_READ, 8'hFF, 1));
    send_request(make_req(REQ_READ, 8'h00, 2));
    send_request(make_req(REQ_BKSP, 8'hFF, 0));
    send_request(make_req(REQ_READ, 8'h00, 3));
    send_request(make_req(REQ_PUT, NEWLINE_CHAR, 'h7FF));
    send_request(make_req(REQ_PUT, 8'h41, 0));
    send_request(make_req(REQ_READ, 8'h00, COLUMNS));
    send_request(make_req(REQ_READ, 8'h00, COLUMNS + 1));
    send_request(make_req(REQ_BKSP, 8'h00, 0));
    send_request(make_req(REQ_READ, 8'h00, COLUMNS));
    send_request(make_req(REQ_CLEAR, 8'hFF, 'h7FF));
    send_request(make_req(REQ_READ, 8'h00, 0));
    send_request(make_req(REQ_READ, 8'h00, CELL_COUNT - 1));
  endtask

  // Attribute register at its extremes and a few patterns
  task automatic test_attribute_settings();
    logic [7:0] attr_values [6];
    attr_values[0] = 8'h00;
    attr_values[1] = 8'hFF;
    attr_values[2] = 8'hA5;
    attr_values[3] = 8'h5A;
    attr_values[4] = 8'($urandom_range(1, 254));
    attr_values[5] = RESET_ATTR;
    foreach (attr_values[k]) begin
      set_attribute(attr_values[k]);
      send_request(make_req(REQ_PUT, rand_char(), $urandom_range(0, 2047)));
      send_request(make_req(REQ_PUT, rand_char(), $urandom_range(0, 2047)));
      send_request(make_req(REQ_BKSP, rand_char(), $urandom_range(0, 2047)));
      send_request(make_req(REQ_READ, rand_char(), cursor_cell()));
      send_request(make_req(REQ_READ, rand_char(), cursor_cell() - 1));
      if (attr_values[k] == 8'hFF) begin
        send_request(make_req(REQ_CLEAR, rand_char(), $urandom_range(0, 2047)));
        send_request(make_req(REQ_READ, rand_char(), $urandom_range(0, CELL_COUNT - 1)));
      end
    end
  endtask

  // Walk to the bottom row, wrap off its end and check that the bottom row
  // survives the scroll unblanked
  task automatic test_screen_fill_and_scroll();
    int col;
    while (cursor_row_q != ROWS - 1)
      send_request(make_req(REQ_PUT, NEWLINE_CHAR, $urandom_range(0, 2047)));
    repeat (COLUMNS - cursor_col_q)
      send_request(make_req(REQ_PUT, rand_char(), $urandom_range(0, 2047)));
    repeat (4) begin
      col = $urandom_range(0, COLUMNS - 1);
      send_request(make_req(REQ_READ, rand_char(), (ROWS - 2) * COLUMNS + col));
      send_request(make_req(REQ_READ, rand_char(), (ROWS - 1) * COLUMNS + col));
    end
    send_request(make_req(REQ_PUT, NEWLINE_CHAR, 0));
    send_request(make_req(REQ_BKSP, rand_char(), 0));
    send_request(make_req(REQ_READ, rand_char(), CELL_COUNT - 1));
  endtask

  // Mixed traffic: mostly text with newlines, runs of characters long enough
  // to wrap, reads around the cursor, a few clears
  task automatic test_random_traffic(input int count);
    in_payload_t req;
    int burst_left;
    int pick;
    burst_left = 0;
    for (int n = 0; n < count; n++) begin
      req  = make_req(REQ_PUT, 8'($urandom_range(0, 255)), $urandom_range(0, 2047));
      pick = $urandom_range(0, 99);
      if (burst_left > 0) begin
        burst_left--;
        req.char_code = rand_char();
      end else if (pick < 2) begin
        burst_left = $urandom_range(10, 80);
      end else if (pick < 48) begin
        // plain put, any byte
      end else if (pick < 60) begin
        req.char_code = NEWLINE_CHAR;
      end else if (pick < 70) begin
        req.req_type = REQ_BKSP;
      end else if (pick < 98) begin
        req.req_type = REQ_READ;
        if (pick[0])
          req.cell_index = IDX_W'($urandom_range(0, cursor_row_q) * COLUMNS
                                  + $urandom_range(0, COLUMNS - 1));
      end else begin
        req.req_type = REQ_CLEAR;
      end
      // clears and scrolls are slow; keep their number bounded
      if (causes_full_pass(req)) begin
        if (full_pass_budget == 0) req.req_type = REQ_READ;
        else full_pass_budget--;
      end
      send_request(req);
      if ($urandom_range(0, 49) == 0) wait_for_drain();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    in_valid         = 1'b0;
    in_data          = '0;
    out_ready        = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    rst_n            = 1'b0;
    cycle_count      = 0;
    error_count      = 0;
    response_count   = 0;
    scroll_total     = 0;
    oob_reads        = 0;
    full_pass_budget = PASS_BUDGET;
    foreach (count_by_kind[k]) count_by_kind[k] = 0;
    send_idle_pct    = 8;
    recv_stall_pct   = 63;
    reset_console();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_and_edges();
    wait_for_drain();
    test_attribute_settings();
    test_screen_fill_and_scroll();
    test_random_traffic(230);

    set_attribute(8'($urandom_range(0, 255)));
    send_idle_pct  = 63;
    recv_stall_pct = 8;
    test_random_traffic(230);

    set_attribute(8'($urandom_range(0, 255)));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(230);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Coverage: %0d puts, %0d backspaces, %0d clears, %0d reads (%0d out of range)",
             count_by_kind[REQ_PUT], count_by_kind[REQ_BKSP], count_by_kind[REQ_CLEAR],
             count_by_kind[REQ_READ], oob_reads);
    $display("%0d scrolls, %0d responses checked, %0d mismatches, %0d cycles",
             scroll_total, response_count, error_count, cycle_count);
    if (error_count == 0 && pending_responses.size() == 0) begin
      $display("** text_console_writer: PASSED **");
    end else begin
      $display("** text_console_writer: FAILED **");
    end
    $finish;
  end

endmodule
